// File: hw/rtl/ccd_pkg.sv
// ----------------------------------------------------------------------------
// ccd_pkg
// Shared types, register indexes, range codes and scale helpers for the
// cyclic CA-CFAR Doppler detector.
// ----------------------------------------------------------------------------
package ccd_pkg;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_REF_CELLS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GUARD_CELLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_GAIN  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_THRESH = 2'd3;

   // range band codes, classified from range_norm (thousandths)
   localparam logic [2:0] RNG_UNITY = 3'd0;
   localparam logic [2:0] RNG_B600  = 3'd1;
   localparam logic [2:0] RNG_B700  = 3'd2;
   localparam logic [2:0] RNG_B900  = 3'd3;
   localparam logic [2:0] RNG_B1000 = 3'd4;

   localparam logic [6:0] BASE0_FACTOR = 7'd120;

   // floor(y/100) == (y * RECIP_100) >> RECIP_SHIFT for every y below 2^31
   localparam logic [31:0] RECIP_100   = 32'd2748779070;
   localparam int          RECIP_SHIFT = 38;

   typedef struct packed {
      logic [2:0] range_code;
      logic [6:0] count;
   } job_type;

   function automatic logic [6:0] alpha_factor(input logic [2:0] code);
      logic [6:0] f;
      case (code)
         RNG_B600:  f = 7'd85;
         RNG_B700:  f = 7'd80;
         RNG_B900:  f = 7'd70;
         RNG_B1000: f = 7'd60;
         default:   f = 7'd100;
      endcase
      return f;
   endfunction

   function automatic logic [6:0] base_factor(input logic [2:0] code);
      logic [6:0] f;
      case (code)
         RNG_B600:  f = 7'd95;
         RNG_B700:  f = 7'd90;
         RNG_B900:  f = 7'd85;
         RNG_B1000: f = 7'd80;
         default:   f = 7'd100;
      endcase
      return f;
   endfunction

   function automatic logic [24:0] div100(input logic [30:0] y);
      logic [62:0] p;
      p = 63'(y) * 63'(RECIP_100);
      return p[62:RECIP_SHIFT];
   endfunction

endpackage

// File: hw/rtl/ccd_front.sv
// ----------------------------------------------------------------------------
// ccd_front
// Request side: writes samples into the line store, counts the fill and
// turns the last sample into a line job with its range band.
// ----------------------------------------------------------------------------
module ccd_front import ccd_pkg::*; #(
   parameter int MAX_CELLS   = 64,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [39:0]                  req_tdata,   // sample[23:0], range_norm[35:24]
   input  logic                         req_tlast,
   input  logic                         line_pending,
   input  logic                         job_full,
   output logic                         store_we,
   output logic [$clog2(MAX_CELLS)-1:0] store_addr,
   output logic [SAMPLE_BITS-1:0]       store_wdata,
   output logic                         job_push,
   output job_type                      job_out
);
   localparam int AW = $clog2(MAX_CELLS);
   localparam int NW = $clog2(MAX_CELLS + 1);

   logic [NW-1:0] fill_ff, fill_in;
   logic          accept, full;
   logic [11:0]   range_norm;
   logic [NW-1:0] count;

   assign req_tready  = !line_pending && !job_full;
   assign accept      = req_tvalid && req_tready;
   assign full        = (fill_ff == NW'(MAX_CELLS));
   assign store_we    = accept && !full;
   assign store_addr  = fill_ff[AW-1:0];
   assign store_wdata = SAMPLE_BITS'(req_tdata[23:0]);
   assign range_norm  = req_tdata[35:24];
   // a sample arriving on a full store is dropped, a last one still closes the line
   assign count       = full ? fill_ff : fill_ff + NW'(1);
   assign job_push    = accept && req_tlast;

   always_comb begin
      job_out.count = 7'(count);
      if (range_norm > 12'd500 && range_norm <= 12'd600) begin
         job_out.range_code = RNG_B600;
      end else if (range_norm > 12'd600 && range_norm <= 12'd700) begin
         job_out.range_code = RNG_B700;
      end else if (range_norm > 12'd700 && range_norm <= 12'd900) begin
         job_out.range_code = RNG_B900;
      end else if (range_norm > 12'd900 && range_norm <= 12'd1000) begin
         job_out.range_code = RNG_B1000;
      end else begin
         job_out.range_code = RNG_UNITY;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         fill_in = req_tlast ? '0 : count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

// File: hw/rtl/ccd_queue.sv
// ----------------------------------------------------------------------------
// ccd_queue
// Two-entry job queue between the loader and the detection engine.
// ----------------------------------------------------------------------------
module ccd_queue import ccd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head,
   output logic    empty,
   output logic    full
);
   job_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] used_ff;
   logic       do_push, do_pop;

   assign empty   = (used_ff == 2'd0);
   assign full    = (used_ff == 2'd2);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         used_ff   <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         used_ff <= used_ff + 2'(do_push) - 2'(do_pop);
      end
   end

endmodule

// File: hw/rtl/ccd_back.sv
// ----------------------------------------------------------------------------
// ccd_back
// Detection engine: holds the line store, scales alpha and the base
// thresholds per line, then walks the cells one by one with a two-port
// window accumulation and a split threshold multiply.
// ----------------------------------------------------------------------------
module ccd_back import ccd_pkg::*; #(
   parameter int MAX_CELLS   = 64,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         store_we,
   input  logic [$clog2(MAX_CELLS)-1:0] store_addr,
   input  logic [SAMPLE_BITS-1:0]       store_wdata,
   input  logic                         job_valid,
   input  job_type                      job_head,
   output logic                         job_pop,
   input  logic [4:0]                   ref_cells,
   input  logic [3:0]                   guard_cells,
   input  logic [15:0]                  alpha_gain,
   input  logic [23:0]                  base_threshold,
   output logic                         busy,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [39:0]                  rsp_tdata,   // cell_index[5:0], detected[6], threshold[38:7]
   output logic                         rsp_tlast    // end_of_line
);
   localparam int AW     = $clog2(MAX_CELLS);
   localparam int NW     = $clog2(MAX_CELLS + 1);
   localparam int SUM_W  = SAMPLE_BITS + 6;
   localparam int LO_W   = SUM_W / 2;
   localparam int HI_W   = SUM_W - LO_W;
   localparam int PROD_W = SUM_W + 16;
   localparam int T_W    = PROD_W - 12;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SMUL  = 4'd1;
   localparam logic [3:0] ST_SDIV  = 4'd2;
   localparam logic [3:0] ST_GMOD  = 4'd3;
   localparam logic [3:0] ST_NB_A  = 4'd4;
   localparam logic [3:0] ST_NB_B  = 4'd5;
   localparam logic [3:0] ST_NB_C  = 4'd6;
   localparam logic [3:0] ST_WIN   = 4'd7;
   localparam logic [3:0] ST_MULLO = 4'd8;
   localparam logic [3:0] ST_MULHI = 4'd9;
   localparam logic [3:0] ST_FIN   = 4'd10;
   localparam logic [3:0] ST_OUT   = 4'd11;

   logic [SAMPLE_BITS-1:0] line_store_ff [MAX_CELLS];
   logic [SAMPLE_BITS-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0]          rd_a_addr, rd_b_addr;

   logic [3:0]        state_ff;
   logic [NW-1:0]     n_ff;
   logic [2:0]        code_ff;
   logic [22:0]       pa_ff;
   logic [30:0]       pb_ff, p0_ff;
   logic [15:0]       alpha_s_ff;
   logic [23:0]       base_s_ff;
   logic [24:0]       base0_ff;
   logic [4:0]        d0_ff;
   logic [AW-1:0]     i_ff, d_ff;
   logic [4:0]        k_ff;
   logic              acc_v_ff;
   logic [SAMPLE_BITS-1:0] x_ff, prev_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [31:0]       th_ff;
   logic              det_ff;
   logic              rsp_v_ff, rsp_det_ff, rsp_last_ff;
   logic [31:0]       rsp_th_ff;
   logic [5:0]        rsp_idx_ff;

   logic [NW:0]  ii, dd, nn, left_w, right_w, prev_w, next_w;
   logic         last_cell, peak, out_free;
   logic [32:0]  bt;
   logic [T_W-1:0] t_val;
   logic [63:0]  t_ext;
   logic [31:0]  t_sat;
   logic [AW-1:0] d_next;

   assign busy       = (state_ff != ST_IDLE);
   assign job_pop    = (state_ff == ST_IDLE) && job_valid;
   assign out_free   = !rsp_v_ff || rsp_tready;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {1'b0, rsp_th_ff, rsp_det_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;

   // cyclic index arithmetic; all operands stay below n
   always_comb begin
      ii      = (NW+1)'(i_ff);
      dd      = (NW+1)'(d_ff);
      nn      = (NW+1)'(n_ff);
      left_w  = (ii >= dd) ? ii - dd : ii + nn - dd;
      right_w = ii + dd;
      if (right_w >= nn) right_w = right_w - nn;
      prev_w  = (ii == '0) ? nn - (NW+1)'(1) : ii - (NW+1)'(1);
      next_w  = (ii + (NW+1)'(1) == nn) ? '0 : ii + (NW+1)'(1);
      last_cell = (ii + (NW+1)'(1) == nn);
      d_next  = ((NW+1)'(d_ff) + (NW+1)'(1) == nn) ? '0 : d_ff + AW'(1);
   end

   always_comb begin
      rd_a_addr = i_ff;
      rd_b_addr = prev_w[AW-1:0];
      case (state_ff)
         ST_NB_B: begin
            rd_a_addr = next_w[AW-1:0];
         end
         ST_WIN: begin
            rd_a_addr = left_w[AW-1:0];
            rd_b_addr = right_w[AW-1:0];
         end
         default: begin
         end
      endcase
   end

   // cell 0 is held against the unscaled base raised by a fifth
   always_comb begin
      bt   = (i_ff == '0) ? 33'(base0_ff) : 33'(base_s_ff);
      peak = (33'(x_ff) > bt) && (x_ff > prev_ff) && (x_ff > rd_a_ff)
             && (n_ff >= NW'(3));
      t_val = prod_ff[PROD_W-1:12];
      t_ext = 64'(t_val);
      t_sat = (t_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t_ext[31:0];
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         line_store_ff[store_addr] <= store_wdata;
      end
      rd_a_ff <= line_store_ff[rd_a_addr];
      rd_b_ff <= line_store_ff[rd_b_addr];
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            n_ff    <= NW'(job_head.count);
            code_ff <= job_head.range_code;
         end
         ST_SMUL: begin
            pa_ff <= 23'(alpha_gain) * 23'(alpha_factor(code_ff));
            pb_ff <= 31'(base_threshold) * 31'(base_factor(code_ff));
            p0_ff <= 31'(base_threshold) * 31'(BASE0_FACTOR);
         end
         ST_SDIV: begin
            alpha_s_ff <= 16'(div100(31'(pa_ff)));
            base_s_ff  <= 24'(div100(pb_ff));
            base0_ff   <= div100(p0_ff);
            d0_ff      <= 5'(guard_cells) + 5'd1;
         end
         ST_GMOD: begin
            if (8'(d0_ff) >= 8'(n_ff)) d0_ff <= d0_ff - 5'(n_ff);
         end
         ST_NB_B: begin
            x_ff    <= rd_a_ff;
            prev_ff <= rd_b_ff;
         end
         ST_NB_C: begin
            sum_ff <= '0;
            k_ff   <= '0;
            d_ff   <= AW'(d0_ff);
            th_ff  <= '0;
            det_ff <= 1'b0;
         end
         ST_WIN: begin
            if (acc_v_ff) sum_ff <= sum_ff + SUM_W'(rd_a_ff) + SUM_W'(rd_b_ff);
            if (k_ff != ref_cells) begin
               k_ff <= k_ff + 5'd1;
               d_ff <= d_next;
            end
         end
         ST_MULLO: begin
            prod_ff <= PROD_W'(sum_ff[LO_W-1:0] * (LO_W+16)'(alpha_s_ff));
         end
         ST_MULHI: begin
            prod_ff <= prod_ff
                       + (PROD_W'(sum_ff[SUM_W-1:LO_W] * (HI_W+16)'(alpha_s_ff)) << LO_W);
         end
         ST_FIN: begin
            th_ff  <= t_sat;
            det_ff <= 33'(x_ff) > 33'(t_sat);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_idx_ff  <= 6'(i_ff);
         rsp_det_ff  <= det_ff;
         rsp_th_ff   <= th_ff;
         rsp_last_ff <= last_cell;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         acc_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (state_ff == ST_OUT && out_free) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_v_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (job_valid) state_ff <= ST_SMUL;
            end
            ST_SMUL: state_ff <= ST_SDIV;
            ST_SDIV: state_ff <= ST_GMOD;
            ST_GMOD: begin
               if (8'(d0_ff) < 8'(n_ff)) begin
                  i_ff     <= '0;
                  state_ff <= ST_NB_A;
               end
            end
            ST_NB_A: state_ff <= ST_NB_B;
            ST_NB_B: state_ff <= ST_NB_C;
            ST_NB_C: begin
               acc_v_ff <= 1'b0;
               state_ff <= peak ? ST_WIN : ST_OUT;
            end
            ST_WIN: begin
               acc_v_ff <= (k_ff != ref_cells);
               if (k_ff == ref_cells && !acc_v_ff) state_ff <= ST_MULLO;
            end
            ST_MULLO: state_ff <= ST_MULHI;
            ST_MULHI: state_ff <= ST_FIN;
            ST_FIN:   state_ff <= ST_OUT;
            ST_OUT: begin
               if (out_free) begin
                  if (last_cell) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     i_ff     <= i_ff + AW'(1);
                     state_ff <= ST_NB_A;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// File: hw/rtl/ca_cfar_cyclic_doppler_detector_unit.sv
// ----------------------------------------------------------------------------
// ca_cfar_cyclic_doppler_detector_unit
// Cyclic cell-averaging CFAR over one Doppler line: loader, job queue and
// detection engine.
// ----------------------------------------------------------------------------
// Loading takes one sample per cycle; a line is closed by the request with tlast.
// Per line, setup runs job pop, scale multiply, reciprocal divide and guard
// wrap; the wrap takes longest on the shortest lines.
// Per cell: only peak cells are tested, walking the window over the two-port
// store before the split multiply; results leave through an output register.
// Requests are held off while a line is being detected.
// Reset clears control and loads CSR defaults; datapath regs and line store are not cleared.
module ca_cfar_cyclic_doppler_detector_unit import ccd_pkg::*; #(
   parameter int MAX_CELLS   = 64,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [39:0]           req_tdata,   // sample[23:0], range_norm[35:24]
   input  logic                  req_tlast,   // last
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,   // cell_index[5:0], detected[6], threshold[38:7]
   output logic                  rsp_tlast,   // end_of_line
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int AW = $clog2(MAX_CELLS);

   logic [4:0]  ref_cells_ff;
   logic [3:0]  guard_cells_ff;
   logic [15:0] alpha_gain_ff;
   logic [23:0] base_threshold_ff;

   logic                   store_we;
   logic [AW-1:0]          store_addr;
   logic [SAMPLE_BITS-1:0] store_wdata;
   logic                   job_push, job_pop, q_empty, q_full, back_busy, line_pending;
   job_type                job_in, job_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_cells_ff      <= 5'd8;
         guard_cells_ff    <= 4'd2;
         alpha_gain_ff     <= 16'd4096;
         base_threshold_ff <= 24'd0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_REF_CELLS:   ref_cells_ff      <= csr_wdata[4:0];
            CSR_GUARD_CELLS: guard_cells_ff    <= csr_wdata[3:0];
            CSR_ALPHA_GAIN:  alpha_gain_ff     <= csr_wdata[15:0];
            CSR_BASE_THRESH: base_threshold_ff <= csr_wdata[23:0];
            default: begin
            end
         endcase
      end
   end

   assign line_pending = back_busy || !q_empty;

   ccd_front #(.MAX_CELLS(MAX_CELLS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .line_pending (line_pending),
      .job_full     (q_full),
      .store_we     (store_we),
      .store_addr   (store_addr),
      .store_wdata  (store_wdata),
      .job_push     (job_push),
      .job_out      (job_in)
   );

   ccd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job_in),
      .pop      (job_pop),
      .head     (job_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   ccd_back #(.MAX_CELLS(MAX_CELLS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .store_we       (store_we),
      .store_addr     (store_addr),
      .store_wdata    (store_wdata),
      .job_valid      (!q_empty),
      .job_head       (job_head),
      .job_pop        (job_pop),
      .ref_cells      (ref_cells_ff),
      .guard_cells    (guard_cells_ff),
      .alpha_gain     (alpha_gain_ff),
      .base_threshold (base_threshold_ff),
      .busy           (back_busy),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast)
   );

   // the store is never written while a line is being detected
   a_no_write_during_detect: assert property (@(posedge clock) disable iff (reset)
      store_we |-> !line_pending)
      else $error("line store written while a line is pending");

   // a job is never pushed into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !q_full)
      else $error("job pushed into full queue");

   // a line job always carries at least one cell
   a_job_nonempty: assert property (@(posedge clock) disable iff (reset)
      job_push |-> (job_in.count != 7'd0))
      else $error("empty line job");

   // requests are refused for the cycle after a line is closed
   a_stall_after_last: assert property (@(posedge clock) disable iff (reset)
      job_push |=> !req_tready)
      else $error("request accepted right after line close");

endmodule
